// ===== design/frb_pkg.sv =====
// shared constants, types and helpers of the fire blur core
`default_nettype none

package frb_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int MIN_DIM    = 4;
    localparam int HIST_DEPTH = MAX_WIDTH + 1;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int POS_W      = 20;
    localparam int ROW_W      = POS_W - $clog2(MIN_DIM);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SUM_W      = PIX_W + 3;
    localparam int DIV_STEPS  = POS_W;
    localparam int BUSY_W     = $clog2(DIV_STEPS + 1);
    localparam int ADDR_W     = 3;
    localparam int APB_W      = 32;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(320);
    localparam logic [CFG_W-1:0] FRAME_ROWS_RST = CFG_W'(200);

    typedef logic [PIX_W-1:0] pix_t;

    // word select on paddr[2]
    typedef enum logic {
        REG_LINE_WIDTH = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } reg_sel_t;

    // reload steps of the row-above window after a register write
    typedef enum logic [1:0] {
        REFILL_NONE,
        REFILL_FAR,
        REFILL_MID,
        REFILL_NEAR
    } refill_t;

    typedef struct packed {
        logic             commit;
        pix_t             result;
        logic [CFG_W-1:0] width;
        refill_t          refill;
    } hist_ctl_t;

    typedef struct packed {
        pix_t up_left;
        pix_t up;
        pix_t up_right;
    } taps_t;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v < CFG_W'(MIN_DIM)) begin
            r = CFG_W'(MIN_DIM);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/frb_hist.sv =====
// result history ram and the row-above tap window
`default_nettype none

module frb_hist (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire frb_pkg::hist_ctl_t ctl,
    output frb_pkg::taps_t         taps
);

    localparam logic [frb_pkg::HIST_AW:0] DEPTH_X =
        (frb_pkg::HIST_AW + 1)'(frb_pkg::HIST_DEPTH);

    frb_pkg::pix_t mem [frb_pkg::HIST_DEPTH];

    logic [frb_pkg::HIST_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [frb_pkg::FILL_W-1:0]  fill_reg, fill_next;
    frb_pkg::pix_t               rd_data_reg;
    logic                        rd_valid_reg, rd_valid_next;
    frb_pkg::pix_t               up_left_reg, up_reg;
    frb_pkg::pix_t               rd_eff;
    logic [frb_pkg::CFG_W-1:0]   back_dist;
    logic [frb_pkg::HIST_AW:0]   addr_sum, addr_wrap;
    logic [frb_pkg::HIST_AW-1:0] rd_addr;

    // distance back from the next write slot
    always_comb begin
        case (ctl.refill)
            frb_pkg::REFILL_FAR: back_dist = ctl.width + frb_pkg::CFG_W'(1);
            frb_pkg::REFILL_MID: back_dist = ctl.width;
            default:             back_dist = ctl.width - frb_pkg::CFG_W'(1);
        endcase
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (ctl.commit) begin
            if (wr_ptr_reg == frb_pkg::HIST_AW'(frb_pkg::HIST_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + frb_pkg::HIST_AW'(1);
            end
            if (fill_reg != frb_pkg::FILL_W'(frb_pkg::HIST_DEPTH)) begin
                fill_next = fill_reg + frb_pkg::FILL_W'(1);
            end
        end
    end

    // circular address, modulo the ram depth
    assign addr_sum  = {1'b0, wr_ptr_next} + DEPTH_X - (frb_pkg::HIST_AW + 1)'(back_dist);
    assign addr_wrap = addr_sum - DEPTH_X;
    assign rd_addr   = (addr_sum >= DEPTH_X) ? addr_wrap[frb_pkg::HIST_AW-1:0]
                                             : addr_sum[frb_pkg::HIST_AW-1:0];

    // entries not yet written read as zero
    assign rd_valid_next = frb_pkg::CFG_W'(fill_next) >= back_dist;
    assign rd_eff        = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            mem[wr_ptr_reg] <= ctl.result;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
            up_left_reg  <= '0;
            up_reg       <= '0;
        end else begin
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            rd_valid_reg <= rd_valid_next;
            case (ctl.refill)
                frb_pkg::REFILL_MID: begin
                    up_left_reg <= rd_eff;
                end
                frb_pkg::REFILL_NEAR: begin
                    up_reg <= rd_eff;
                end
                frb_pkg::REFILL_NONE: begin
                    if (ctl.commit) begin
                        up_left_reg <= up_reg;
                        up_reg      <= rd_eff;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign taps.up_left  = up_left_reg;
    assign taps.up       = up_reg;
    assign taps.up_right = rd_eff;

endmodule

`default_nettype wire

// ===== design/fire_recursive_blur_core.sv =====
// fire blur core: streaming recursive blur over an 8-bit raster frame
//
// Takes and returns one pixel per cycle via the input and result registers
// unless the output or a register write stalls the flow; the left-neighbor
// feedback closes through a single adder tree so back-to-back pixels never
// wait on each other. The row above comes from a 1025-entry history ram
// with one read port, read one pixel ahead into a three-tap window. Every
// register write blocks the input while a one-bit-per-cycle
// divider derives row and column from the current position for the new
// width and the tap window is reloaded from the ram. tdata carries
// center/right/below pixels, tuser marks the first pixel of a frame and
// tlast on the output marks its last pixel. No clearing pass after reset.
`default_nettype none

module fire_recursive_blur_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [7:0] center_pixel, [15:8] right_pixel, [23:16] below_pixel
    input  wire logic [3*frb_pkg::PIX_W-1:0]  s_tdata,
    // [0] frame_start
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [7:0] out_pixel
    output logic [frb_pkg::PIX_W-1:0]         m_tdata,
    output logic                              m_tlast,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [frb_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [frb_pkg::APB_W-1:0]    pwdata,
    output logic [frb_pkg::APB_W-1:0]         prdata,
    output logic                              pready
);

    logic [frb_pkg::CFG_W-1:0] line_width_reg, frame_rows_reg;
    logic [frb_pkg::CFG_W-1:0] w_cl, h_cl;
    logic [2*frb_pkg::CFG_W-1:0] area;
    logic [frb_pkg::POS_W-1:0] tot_m1_reg;
    logic                      cfg_wr;

    logic [frb_pkg::BUSY_W-1:0] busy_cnt_reg;
    frb_pkg::refill_t           refill;
    logic [frb_pkg::POS_W-1:0]  div_q_reg, div_q_next;
    logic [frb_pkg::CFG_W-1:0]  div_r_reg, div_r_next;
    logic [frb_pkg::CFG_W:0]    div_sh;
    logic                       div_ge;

    logic                a_valid_reg, a_start_reg;
    frb_pkg::pix_t       a_c_reg, a_r_reg, a_b_reg;
    logic                out_valid_reg, out_last_reg;
    frb_pkg::pix_t       out_pix_reg;
    frb_pkg::pix_t       left_reg;
    logic                out_free, commit;

    logic [frb_pkg::POS_W-1:0] pos_reg, pos_cur;
    logic [frb_pkg::COL_W-1:0] col_reg, col_cur;
    logic [frb_pkg::ROW_W-1:0] row_reg, row_cur;
    logic [frb_pkg::CFG_W-1:0] col_inc;
    logic                      is_last, pass;
    logic [frb_pkg::SUM_W-1:0] sum;
    frb_pkg::pix_t             res;

    frb_pkg::hist_ctl_t hist_ctl;
    frb_pkg::taps_t     taps;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (frb_pkg::reg_sel_t'(paddr[2]))
            frb_pkg::REG_LINE_WIDTH: prdata = frb_pkg::APB_W'(line_width_reg);
            frb_pkg::REG_FRAME_ROWS: prdata = frb_pkg::APB_W'(frame_rows_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= frb_pkg::LINE_WIDTH_RST;
            frame_rows_reg <= frb_pkg::FRAME_ROWS_RST;
        end else if (cfg_wr) begin
            unique case (frb_pkg::reg_sel_t'(paddr[2]))
                frb_pkg::REG_LINE_WIDTH: line_width_reg <= pwdata[frb_pkg::CFG_W-1:0];
                frb_pkg::REG_FRAME_ROWS: frame_rows_reg <= pwdata[frb_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cl = frb_pkg::clamp_dim(line_width_reg, frb_pkg::CFG_W'(frb_pkg::MAX_WIDTH));
    assign h_cl = frb_pkg::clamp_dim(frame_rows_reg, frb_pkg::CFG_W'(frb_pkg::MAX_ROWS));
    assign area = (2*frb_pkg::CFG_W)'(w_cl) * (2*frb_pkg::CFG_W)'(h_cl);

    always_ff @(posedge aclk) begin
        tot_m1_reg <= frb_pkg::POS_W'(area - (2*frb_pkg::CFG_W)'(1));
    end

    // restoring divider: position / width, one quotient bit per cycle
    assign div_sh     = {div_r_reg, div_q_reg[frb_pkg::POS_W-1]};
    assign div_ge     = div_sh >= {1'b0, w_cl};
    assign div_r_next = div_ge ? frb_pkg::CFG_W'(div_sh - {1'b0, w_cl})
                               : div_sh[frb_pkg::CFG_W-1:0];
    assign div_q_next = {div_q_reg[frb_pkg::POS_W-2:0], div_ge};

    always_comb begin
        case (busy_cnt_reg)
            frb_pkg::BUSY_W'(3): refill = frb_pkg::REFILL_FAR;
            frb_pkg::BUSY_W'(2): refill = frb_pkg::REFILL_MID;
            frb_pkg::BUSY_W'(1): refill = frb_pkg::REFILL_NEAR;
            default:             refill = frb_pkg::REFILL_NONE;
        endcase
    end

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign commit   = a_valid_reg && out_free;
    assign s_tready = (busy_cnt_reg == '0) && (!a_valid_reg || out_free);

    // position of the pixel in the input register
    assign pos_cur = a_start_reg ? '0 : pos_reg;
    assign col_cur = a_start_reg ? '0 : col_reg;
    assign row_cur = a_start_reg ? '0 : row_reg;
    assign col_inc = frb_pkg::CFG_W'(col_cur) + frb_pkg::CFG_W'(1);

    assign is_last = pos_cur >= tot_m1_reg;
    assign pass    = is_last || (row_cur < frb_pkg::ROW_W'(2))
                  || (row_cur >= frb_pkg::ROW_W'(h_cl) - frb_pkg::ROW_W'(1));

    // 1.75 x center as c + c/2 + c/4
    assign sum = frb_pkg::SUM_W'(taps.up_left) + frb_pkg::SUM_W'(taps.up)
               + frb_pkg::SUM_W'(taps.up_right) + frb_pkg::SUM_W'(left_reg)
               + frb_pkg::SUM_W'(a_c_reg) + frb_pkg::SUM_W'(a_c_reg >> 1)
               + frb_pkg::SUM_W'(a_c_reg >> 2) + frb_pkg::SUM_W'(a_r_reg)
               + frb_pkg::SUM_W'(a_b_reg);
    assign res = pass ? a_c_reg : sum[frb_pkg::SUM_W-1:3];

    assign hist_ctl.commit = commit;
    assign hist_ctl.result = res;
    assign hist_ctl.width  = w_cl;
    assign hist_ctl.refill = refill;

    frb_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (hist_ctl),
        .taps    (taps)
    );

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_c_reg     <= s_tdata[frb_pkg::PIX_W-1:0];
            a_r_reg     <= s_tdata[2*frb_pkg::PIX_W-1:frb_pkg::PIX_W];
            a_b_reg     <= s_tdata[3*frb_pkg::PIX_W-1:2*frb_pkg::PIX_W];
            a_start_reg <= s_tuser;
        end
        if (commit) begin
            out_pix_reg  <= res;
            out_last_reg <= is_last;
        end
        if (cfg_wr) begin
            div_q_reg <= pos_reg;
            div_r_reg <= '0;
        end else if (busy_cnt_reg != '0) begin
            div_q_reg <= div_q_next;
            div_r_reg <= div_r_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_cnt_reg  <= '0;
            left_reg      <= '0;
            pos_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                a_valid_reg <= 1'b1;
            end else if (commit) begin
                a_valid_reg <= 1'b0;
            end
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr) begin
                busy_cnt_reg <= frb_pkg::BUSY_W'(frb_pkg::DIV_STEPS);
            end else if (busy_cnt_reg != '0) begin
                busy_cnt_reg <= busy_cnt_reg - frb_pkg::BUSY_W'(1);
                if (busy_cnt_reg == frb_pkg::BUSY_W'(1)) begin
                    row_reg <= div_q_next[frb_pkg::ROW_W-1:0];
                    col_reg <= div_r_next[frb_pkg::COL_W-1:0];
                end
            end

            if (commit) begin
                left_reg <= res;
                if (is_last) begin
                    pos_reg <= '0;
                    col_reg <= '0;
                    row_reg <= '0;
                end else begin
                    pos_reg <= pos_cur + frb_pkg::POS_W'(1);
                    if (col_inc == w_cl) begin
                        col_reg <= '0;
                        row_reg <= row_cur + frb_pkg::ROW_W'(1);
                    end else begin
                        col_reg <= col_inc[frb_pkg::COL_W-1:0];
                        row_reg <= row_cur;
                    end
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/frb_checker.sv =====
// port-level checks for the fire blur core, bound to the top level
`default_nettype none

module frb_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [frb_pkg::PIX_W-1:0]    m_tdata,
    input wire logic                         m_tlast,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // register write blocks the input while position and window are rebuilt
    a_cfg_block: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite |=> !s_tready)
        else $error("input accepted right after a register write");

    // once an accepted pixel has passed the input and result registers, a result is valid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("result missing two cycles after input");

endmodule

bind fire_recursive_blur_core frb_checker u_frb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite)
);

`default_nettype wire

// ===== sim/fire_recursive_blur_checker.sv =====
// checker for the fire blur core: tracks config writes, predicts each output pixel, compares
module fire_recursive_blur_checker
    import frb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [3*PIX_W-1:0]  s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [PIX_W-1:0]    m_tdata,
    input  logic                m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output int                  mismatches,
    output int                  outstanding,
    output int                  results_checked,
    output int                  blurred_pixels,
    output int                  frame_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        pix_t pixel;
        logic frame_end;
    } blur_result_t;

    logic [CFG_W-1:0] line_width_q;
    logic [CFG_W-1:0] frame_rows_q;
    pix_t             history [HIST_DEPTH];
    int unsigned      newest;
    int unsigned      position;
    blur_result_t     expected_pixels [$];
    blur_result_t     want;

    function automatic int unsigned bounded_dim(input logic [CFG_W-1:0] v,
                                                input int unsigned hi);
        int unsigned r;
        r = v;
        if (r < MIN_DIM) begin
            r = MIN_DIM;
        end else if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // blurred result produced 'age' pixels ago, age 0 is the left neighbor
    function automatic pix_t past_result(input int unsigned age);
        return history[(newest + HIST_DEPTH - age) % HIST_DEPTH];
    endfunction

    task automatic predict_pixel(input pix_t c, input pix_t r, input pix_t b,
                                 input logic start);
        int unsigned w;
        int unsigned h;
        int unsigned pos;
        int unsigned sum;
        pix_t        res;
        logic        last;
        w = bounded_dim(line_width_q, MAX_WIDTH);
        h = bounded_dim(frame_rows_q, MAX_ROWS);
        if (start) begin
            position = 0;
        end
        pos  = position;
        last = pos >= w * h - 1;
        if (last || pos / w < 2 || pos / w >= h - 1) begin
            res = c;
        end else begin
            // row above and left neighbor are already blurred; center weighs 1.75
            sum = past_result(w) + past_result(w - 1) + past_result(w - 2) + past_result(0)
                + c + (c >> 1) + (c >> 2) + r + b;
            res = pix_t'(sum >> 3);
            blurred_pixels++;
        end
        newest = (newest + 1) % HIST_DEPTH;
        history[newest] = res;
        position = last ? 0 : (pos + 1) & ((1 << POS_W) - 1);
        expected_pixels.push_back('{res, last});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_width_q = LINE_WIDTH_RST;
            frame_rows_q = FRAME_ROWS_RST;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                history[i] = '0;
            end
            newest   = 0;
            position = 0;
            expected_pixels.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (reg_sel_t'(paddr[2]) == REG_LINE_WIDTH) begin
                    line_width_q = pwdata[CFG_W-1:0];
                end else begin
                    frame_rows_q = pwdata[CFG_W-1:0];
                end
            end
            // retire the output transaction before queuing this edge's input
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result pixel %0d frame_end %0b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    results_checked++;
                    if (want.frame_end) begin
                        frame_ends++;
                    end
                    if (m_tdata !== want.pixel) begin
                        $display("%0t: out_pixel expected %0d, got %0d",
                                 $time, want.pixel, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.frame_end) begin
                        $display("%0t: frame_end expected %0b, got %0b",
                                 $time, want.frame_end, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_pixel(s_tdata[PIX_W-1:0], s_tdata[2*PIX_W-1:PIX_W],
                              s_tdata[3*PIX_W-1:2*PIX_W], s_tuser);
            end
        end
        outstanding <= expected_pixels.size();
    end

endmodule

// ===== sim/tb_fire_recursive_blur_core.sv =====
// testbench top for the fire blur core: stimulus, flow control and verdict
module tb_fire_recursive_blur_core;
    timeunit 1ns;
    timeprecision 1ps;
    import frb_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // [7:0] center_pixel, [15:8] right_pixel, [23:16] below_pixel
    logic [3*PIX_W-1:0]  s_tdata  = '0;
    // [0] frame_start
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [7:0] out_pixel
    logic [PIX_W-1:0]    m_tdata;
    logic                m_tlast;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [APB_W-1:0]    pwdata   = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    int mismatches;
    int outstanding;
    int results_checked;
    int blurred_pixels;
    int frame_ends;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pixels_sent    = 0;
    int quiet_cycles   = 0;

    fire_recursive_blur_core uut (.*);

    fire_recursive_blur_checker blur_check (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb_fire_recursive_blur_core failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic pix_t rand_pix();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
    endtask

    task automatic send_pixel(input pix_t c, input pix_t r, input pix_t b, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, r, c};
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input reg_sel_t sel, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        // junk above the register width must be dropped
        pwdata  <= ($urandom() & ~32'h7FF) | (value & 32'h7FF);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input int unsigned width, input int unsigned rows);
        wait_drained();
        write_reg(REG_LINE_WIDTH, width);
        write_reg(REG_FRAME_ROWS, rows);
    endtask

    // frames of frame_len pixels; irregular mixes in missing, stray and truncated frame starts
    task automatic run_frames(input int n_items, input int frame_len, input bit irregular);
        int   sent;
        int   i;
        int   kind;
        int   len_this;
        logic start_flag;
        sent = 0;
        while (sent < n_items) begin
            kind     = irregular ? $urandom_range(99) : 50;
            len_this = (kind < 10) ? $urandom_range(frame_len, 1) : frame_len;
            for (i = 0; i < len_this && sent < n_items; i++) begin
                start_flag = (i == 0 && kind >= 5) || (kind >= 90 && $urandom_range(15) == 0);
                if (sent == n_items / 2) begin
                    wait_drained();
                end
                send_pixel(rand_pix(), rand_pix(), rand_pix(), start_flag);
                sent++;
            end
        end
    endtask

    initial begin
        int p;
        int w;
        int h;
        int i;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // default geometry: first rows pass through
        set_idling(0);
        send_pixel('0, '1, '0, 1'b1);
        send_pixel('1, '0, '1, 1'b0);
        send_pixel('1, '1, '1, 1'b0);

        // smallest frame, all white: the blurred row hits the 246 ceiling
        set_config(4, 4);
        for (i = 0; i < 16; i++) begin
            send_pixel('1, '1, '1, i == 0);
        end
        send_pixel('0, '0, '0, 1'b1);
        send_pixel('0, '1, '0, 1'b0);
        send_pixel('0, '0, '1, 1'b0);
        send_pixel(8'd1, '0, '0, 1'b0);

        for (p = 0; p < 6; p++) begin
            set_idling(p % 4);
            w = $urandom_range(12, 4);
            h = $urandom_range(8, 4);
            set_config(w, h);
            run_frames(50, w * h, 1'b1);
        end

        // dimensions below the minimum
        set_idling(2);
        set_config(0, 0);
        run_frames(48, 16, 1'b1);
        set_idling(1);
        set_config(3, 3);
        run_frames(48, 16, 1'b1);

        // tallest frame, then shrink so the position lies past the new frame
        set_idling(3);
        set_config(4, 1024);
        run_frames(90, 4096, 1'b0);
        set_config(4, 4);
        for (i = 0; i < 3; i++) begin
            send_pixel(rand_pix(), rand_pix(), rand_pix(), 1'b0);
        end
        run_frames(40, 16, 1'b1);

        set_idling(0);
        set_config(4, 2047);
        run_frames(40, 4096, 1'b0);
        set_idling(2);
        set_config(1024, 5);
        run_frames(40, 5120, 1'b0);

        // long rows: the blur reads deep into the history
        set_idling(3);
        set_config(150, 4);
        run_frames(460, 600, 1'b0);
        set_config(5, 4);
        for (i = 0; i < 3; i++) begin
            send_pixel(rand_pix(), rand_pix(), rand_pix(), 1'b0);
        end
        run_frames(60, 20, 1'b1);

        wait_drained();
        repeat (8) @(posedge aclk);

        $display("sent %0d pixels over widths 4 to 1024 and heights 4 to 1024, four flow patterns",
                 pixels_sent);
        $display("checked %0d results: %0d blurred, %0d frame ends, %0d mismatches",
                 results_checked, blurred_pixels, frame_ends, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_fire_recursive_blur_core passed");
        end else begin
            $display("tb_fire_recursive_blur_core failed");
        end
        $finish;
    end

endmodule
